// ===== design/assert_macros.svh =====
// Assertion macros shared by the calendar generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcd_pkg.sv =====
// Shared types, constants and tables of the month calendar generator.
package mcd_pkg;

  localparam int DIV_W = 16;
  localparam int REM_W = 7;

  // Reciprocals scaled by 2**RECIP_SHIFT. They give exact quotients for every
  // dividend this block produces (below 16800 by 100, below 21000 by 7).
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_CENTURY = 17'd5243;
  localparam logic [RECIP_W-1:0] RECIP_WEEK    = 17'd74899;

  localparam logic [REM_W-1:0] DIVISOR_CENTURY = 7'd100;
  localparam logic [REM_W-1:0] DIVISOR_WEEK    = 7'd7;
  localparam logic [14:0]      YEAR_BIAS       = 15'd400;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Zeller month term, floor(13 * (m + 1) / 5).
  function automatic logic [5:0] zeller_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd0:    t = 6'd2;
      4'd1:    t = 6'd5;
      4'd2:    t = 6'd7;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd41;
    endcase
    return t;
  endfunction

endpackage

// ===== design/mcd_divider.sv =====
// Division by 100 or by 7 through reciprocal multiplication, in a multiply phase and then a remainder phase.
module mcd_divider import mcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [REM_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic [REM_W-1:0] remainder,
  output div_stat_t        stat
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_MUL,
    P_REM
  } phase_t;

  phase_t             phase;
  logic [DIV_W-1:0]   num;
  logic [REM_W-1:0]   dvs;
  logic [RECIP_W-1:0] recip;
  logic [DIV_W-1:0]   quo;
  logic [REM_W-1:0]   rem;
  logic               done;

  logic [DIV_W+RECIP_W-1:0] prod;
  logic [DIV_W-1:0]         back;
  logic [DIV_W-1:0]         diff;

  always_comb begin
    prod = {{RECIP_W{1'b0}}, num} * {{DIV_W{1'b0}}, recip};
    back = quo * DIV_W'(dvs);
    // The remainder stays below the divisor, so it fits in REM_W bits.
    diff = num - back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_REM) && !start;
      if (start) begin
        num   <= dividend;
        dvs   <= divisor;
        // Only the two divisors of the calendar are supported.
        recip <= (divisor == DIVISOR_WEEK) ? RECIP_WEEK : RECIP_CENTURY;
        phase <= P_MUL;
      end else begin
        case (phase)
          P_MUL: begin
            quo   <= DIV_W'(prod[DIV_W+RECIP_W-1:RECIP_SHIFT]);
            phase <= P_REM;
          end
          P_REM: begin
            rem   <= diff[REM_W-1:0];
            phase <= P_IDLE;
          end
          default: begin
            phase <= P_IDLE;
          end
        endcase
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = (phase != P_IDLE);
  assign stat.done = done;

endmodule

// ===== design/month_calendar_day_generator_unit.sv =====
// Throughput: one day beat per cycle while m_tready is high, 28 to 31 beats per item;
// the next input beat is taken only once the last day of the previous item is loaded.
// After an input beat is accepted, the sequencer runs two passes of the shared
// reciprocal divider (by 100, then the week modulo by 7) and then loads the first day.
// Reset: rst, synchronous and active high, clears the sequencer and output valid.
module month_calendar_day_generator_unit import mcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // year[13:0], month_number[17:14], today_day[22:18]
  input  logic        s_tuser,   // is_current_month[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // day_of_month[4:0], weekday[7:5], is_weekend[8],
                                 // is_today[9]
  output logic        m_tlast    // last_of_month
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV100,
    S_MOD7,
    S_EMIT
  } state_t;

  state_t      state;
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  today_r;
  logic        cur_r;
  logic [4:0]  days;
  logic [4:0]  day_cnt;
  logic [2:0]  wd_cur;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [REM_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quot;
  logic [REM_W-1:0] div_rem;
  div_stat_t        div_stat;

  logic             jan_feb;
  logic [14:0]      y;
  logic             r_zero;
  logic [7:0]       q;
  logic [7:0]       qy;
  logic [3:0]       mz;
  logic [DIV_W-1:0] zeller_sum;
  logic             leap;
  logic [4:0]       days_next;
  logic [2:0]       h;
  logic [2:0]       wd_first;
  logic             out_free;
  logic             s_accept;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    jan_feb = (month_r == 4'd1) || (month_r == 4'd2);
    y       = {1'b0, year_r} + YEAR_BIAS - 15'(jan_feb);
    r_zero  = (div_rem == '0);
    q       = div_quot[7:0];
    // The divider saw the unshifted biased year; January and February use one less.
    qy      = q - 8'(jan_feb && r_zero);
    mz      = jan_feb ? (month_r + 4'd12) : month_r;
    zeller_sum = DIV_W'(y) + DIV_W'(y[14:2]) + DIV_W'(zeller_term(mz)) + DIV_W'(1)
               + DIV_W'(qy[7:2]) - DIV_W'(qy);
    // The bias of 400 years leaves the remainders by 4, 100 and 400 unchanged.
    leap = (year_r[1:0] == 2'd0) && (!r_zero || (q[1:0] == 2'd0));
    case (month_r) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_next = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days_next = 5'd30;
      4'd2:    days_next = leap ? 5'd29 : 5'd28;
      default: days_next = 5'd30;
    endcase
    h        = div_rem[2:0];
    wd_first = (h == 3'd0) ? 3'd6 : (h - 3'd1);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'({1'b0, s_tdata[13:0]}) + DIV_W'(YEAR_BIAS);
    div_divisor  = DIVISOR_CENTURY;
    case (state)
      S_IDLE: begin
        div_start = s_accept;
      end
      S_DIV100: begin
        div_start    = div_stat.done;
        div_dividend = zeller_sum;
        div_divisor  = DIVISOR_WEEK;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  mcd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // While emitting, a taken beat is replaced by the next day in the same cycle.
      if (m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            year_r  <= s_tdata[13:0];
            month_r <= s_tdata[17:14];
            today_r <= s_tdata[22:18];
            cur_r   <= s_tuser;
            state   <= S_DIV100;
          end
        end
        S_DIV100: begin
          if (div_stat.done) begin
            days  <= days_next;
            state <= S_MOD7;
          end
        end
        S_MOD7: begin
          if (div_stat.done) begin
            wd_cur  <= wd_first;
            day_cnt <= 5'd1;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, cur_r && (day_cnt == today_r),
                         (wd_cur == 3'd0) || (wd_cur == 3'd6), wd_cur, day_cnt};
            m_tlast  <= (day_cnt == days);
            day_cnt  <= day_cnt + 5'd1;
            wd_cur   <= (wd_cur == 3'd6) ? 3'd0 : (wd_cur + 3'd1);
            if (day_cnt == days) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_last_len, m_tvalid && m_tlast, m_tdata[4:0] >= 5'd28, "run ended before day 28")
  `ASSERT_IMPLIES(a_wd_range, m_tvalid, m_tdata[7:5] != 3'd7, "weekday out of range")
  `ASSERT_IMPLIES(a_div_done, div_stat.done, state == S_DIV100 || state == S_MOD7, "stray divider done")
  `ASSERT_NEXT(a_first_day, state == S_MOD7 && div_stat.done, day_cnt == 5'd1 && days >= 5'd28, "bad run setup")

endmodule

// ===== test/month_calendar_day_generator_unit_tb.sv =====
// Self-checking testbench for the month calendar day generator.
module month_calendar_day_generator_unit_tb;

  localparam int unsigned JANUARY  = 1;
  localparam int unsigned FEBRUARY = 2;
  localparam int unsigned RANDOM_MONTHS = 400;
  localparam int unsigned DRAIN_CYCLES  = 80;

  typedef struct {
    logic [4:0] day;
    logic [2:0] weekday;
    logic       weekend;
    logic       today;
    logic       last;
  } day_beat_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_STARVED, RX_CADENCE} rx_mode_e;

  class calendar_scoreboard;
    day_beat_t expected_days[$];
    int        errors = 0;

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // Expands one accepted month into the day beats it should produce.
    function void note_month(logic [13:0] year, logic [3:0] month, logic [4:0] today_day,
                             logic current);
      int unsigned y, m, h, month_days, wd;
      bit          leap;
      day_beat_t   b;
      case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 31;
        4'd2: begin
          leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
          month_days = leap ? 29 : 28;
        end
        default: month_days = 30;
      endcase
      // The 400-year bias keeps the prior-year step non-negative for year zero.
      y = int'(year) + 400;
      m = 32'(month);
      if (m == JANUARY || m == FEBRUARY) begin
        m += 12;
        y -= 1;
      end
      h = (1 + (13 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
      wd = (h + 6) % 7;
      for (int unsigned d = 1; d <= month_days; d++) begin
        b.day     = d[4:0];
        b.weekday = wd[2:0];
        b.weekend = (wd == 0 || wd == 6);
        b.today   = current && (d == today_day);
        b.last    = (d == month_days);
        expected_days.push_back(b);
        wd = (wd + 1) % 7;
      end
    endfunction

    task check_day(logic [15:0] data, logic tlast);
      day_beat_t e;
      if (expected_days.size() == 0) begin
        flag_mismatch($sformatf("unexpected day beat data=%h last=%b", data, tlast));
        return;
      end
      e = expected_days.pop_front();
      if (data[4:0] !== e.day)
        flag_mismatch($sformatf("day_of_month got %0d want %0d", data[4:0], e.day));
      if (data[7:5] !== e.weekday)
        flag_mismatch($sformatf("weekday got %0d want %0d (day %0d)",
                                data[7:5], e.weekday, e.day));
      if (data[8] !== e.weekend)
        flag_mismatch($sformatf("is_weekend got %b want %b (day %0d)", data[8], e.weekend, e.day));
      if (data[9] !== e.today)
        flag_mismatch($sformatf("is_today got %b want %b (day %0d)", data[9], e.today, e.day));
      if (tlast !== e.last)
        flag_mismatch($sformatf("last_of_month got %b want %b (day %0d)", tlast, e.last, e.day));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  calendar_scoreboard sb = new();
  int unsigned        burst_left = 0;

  month_calendar_day_generator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: a mode is held for a random stretch, then a mode is drawn again.
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_run  = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_run  = $urandom_range(20, 200);
    end
    rx_run--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RX_STARVED: m_tready <= ($urandom_range(0, 3) == 0);
      default:    m_tready <= (rx_tick % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_day(m_tdata, m_tlast);
  end

  task automatic idle_for(int unsigned cycles);
    logic [31:0] noise;
    noise = $urandom;
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= {1'b0, noise[22:0]};
    s_tuser  <= noise[31];
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_month(logic [13:0] year, logic [3:0] month, logic [4:0] today_day,
                            logic current);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, today_day, month, year};
    s_tuser  <= current;
    do @(posedge clk); while (!s_tready);
    sb.note_month(year, month, today_day, current);
    if (burst_left == 0) begin
      idle_for($urandom_range(1, 12));
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random_month();
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  today_day;
    logic        current;
    int unsigned pick;
    pick    = $urandom_range(0, 9);
    current = 1'($urandom_range(0, 1));
    if (pick <= 6) begin
      year      = 14'($urandom_range(1, 9999));
      month     = 4'($urandom_range(1, 12));
      today_day = 5'($urandom_range(1, 31));
    end else if (pick == 7) begin
      // February around the leap-year boundaries: centuries and multiples of four.
      year      = $urandom_range(0, 1) ? 14'($urandom_range(0, 99) * 100)
                                       : 14'($urandom_range(0, 2499) * 4);
      month     = 4'(FEBRUARY);
      today_day = 5'($urandom_range(27, 30));
    end else begin
      year      = 14'($urandom_range(0, 16383));
      month     = 4'($urandom_range(0, 15));
      today_day = 5'($urandom_range(0, 31));
    end
    send_month(year, month, today_day, current);
  endtask

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_month(14'd1, 4'd1, 5'd1, 1'b1);
    send_month(14'd9999, 4'd12, 5'd31, 1'b1);
    send_month(14'd2000, 4'd2, 5'd29, 1'b1);
    send_month(14'd1900, 4'd2, 5'd28, 1'b1);
    send_month(14'd2024, 4'd2, 5'd29, 1'b0);
    send_month(14'd2023, 4'd2, 5'd15, 1'b1);
    send_month(14'd0, 4'd2, 5'd29, 1'b1);
    send_month(14'd16383, 4'd2, 5'd1, 1'b1);
    send_month(14'd10000, 4'd3, 5'd7, 1'b1);
    // Month numbers outside 1..12 run as 30-day months.
    send_month(14'd2024, 4'd0, 5'd30, 1'b1);
    send_month(14'd2024, 4'd13, 5'd31, 1'b1);
    send_month(14'd1999, 4'd14, 5'd0, 1'b1);
    send_month(14'd12345, 4'd15, 5'd16, 1'b1);
    // Today values that can never match, followed by assorted months and years.
    send_month(14'd2025, 4'd7, 5'd0, 1'b1);
    send_month(14'd2025, 4'd4, 5'd31, 1'b1);
    send_month(14'd2024, 4'd2, 5'd30, 1'b1);
    send_month(14'd2025, 4'd5, 5'd10, 1'b1);
    send_month(14'd2025, 4'd6, 5'd30, 1'b1);
    send_month(14'd1582, 4'd8, 5'd31, 1'b0);
    send_month(14'd1752, 4'd9, 5'd3, 1'b1);
    send_month(14'd4000, 4'd10, 5'd25, 1'b1);
    send_month(14'd8191, 4'd11, 5'd2, 1'b1);
    send_month(14'd400, 4'd1, 5'd31, 1'b1);

    for (int i = 0; i < RANDOM_MONTHS; i++) send_random_month();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_days.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
